// ===== rtl/routing_congestion_accumulator_defines.svh =====
// ---------------------------------------------------------------------------
// routing congestion accumulator assertion macros
// shared check macros, clocked on clk and disabled during reset
// ---------------------------------------------------------------------------
`ifndef ROUTING_CONGESTION_ACCUMULATOR_DEFINES_SVH
`define ROUTING_CONGESTION_ACCUMULATOR_DEFINES_SVH

// same-cycle implication
`define RCACC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rcacc check failed");

// next-cycle implication
`define RCACC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rcacc check failed");

`endif

// ===== rtl/rcacc_pkg.sv =====
// ---------------------------------------------------------------------------
// rcacc_pkg
// types and codes shared by the congestion accumulator modules
// ---------------------------------------------------------------------------
package rcacc_pkg;

	localparam int COORD_W   = 24;
	localparam int STEP_W    = 16;
	localparam int CNT_W     = 16;
	localparam int TOT_W     = 32;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 3;
	localparam int DIV_CNT_W = 5;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_REPORT = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_DIAG    = 2'd1,
		STS_OUTSIDE = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_H_CAP    = 3'd0,
		REG_V_CAP    = 3'd1,
		REG_RAW      = 3'd2,
		REG_ORIGIN_L = 3'd3,
		REG_ORIGIN_B = 3'd4,
		REG_X_STEP   = 3'd5,
		REG_Y_STEP   = 3'd6
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_MAP,
		S_MAP_WAIT,
		S_CHECK,
		S_ADDR,
		S_RD,
		S_WR,
		S_RPT,
		S_RPT_END,
		S_CLR,
		S_DONE
	} fsm_t;

	// signed bin index in sign and magnitude form (never minus zero)
	typedef struct packed {
		logic               neg;
		logic [COORD_W-1:0] mag;
	} bin_t;

endpackage

// ===== rtl/rcacc_mem.sv =====
// ---------------------------------------------------------------------------
// rcacc_mem
// single-address synchronous ram, read-first, registered read data
// ---------------------------------------------------------------------------
module rcacc_mem import rcacc_pkg::*; #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [CNT_W-1:0] wdata,
	output logic [CNT_W-1:0] rdata
);

	logic [CNT_W-1:0] mem [DEPTH];
	logic [CNT_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/rcacc_div.sv =====
// ---------------------------------------------------------------------------
// rcacc_div
// raw coordinate to bin mapper, floor((coord - origin) / step), one bit a cycle
// ---------------------------------------------------------------------------
module rcacc_div import rcacc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [COORD_W-1:0] coord,
	input  logic [COORD_W-1:0] origin,
	input  logic [STEP_W-1:0]  step,
	output logic               done,
	output bin_t               res
);

	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(COORD_W - 1);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [COORD_W-1:0]   quo_q;
	logic [STEP_W-1:0]    rem_q;
	logic [STEP_W-1:0]    den_q;
	logic                 neg_q;
	logic [STEP_W:0]      trial;
	logic [STEP_W:0]      diff;
	logic                 fits;

	assign trial = {rem_q, quo_q[COORD_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= coord < origin;
			quo_q <= (coord < origin) ? origin - coord : coord - origin;
			rem_q <= '0;
			den_q <= (step == '0) ? STEP_W'(1) : step;
		end else if (busy_q) begin
			quo_q <= {quo_q[COORD_W-2:0], fits};
			rem_q <= fits ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
		end
	end

	// negative distance rounds toward minus infinity
	assign done    = done_q;
	assign res.neg = neg_q;
	assign res.mag = neg_q ? quo_q + COORD_W'(rem_q != '0) : quo_q;

endmodule

// ===== rtl/routing_congestion_accumulator.sv =====
// ---------------------------------------------------------------------------
// routing_congestion_accumulator
// horizontal and vertical cut usage grids in two rams, running wire length,
// segment add, overflow report and clear commands
// ---------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_stall  | command, x_start, y_start, x_end, y_end
//  out      | out_valid / out_stall| status, segment_length, total_length,
//           |                      | h_overflow, v_overflow, overflow_sum
//  cfg      | cfg_write            | cfg_index, cfg_data
//
//  add: a ram read and write per covered cut, after bin mapping of the four coordinates in
//    raw mode (one quotient bit a cycle in the shared divider)
//  report: one ram address read per cycle across all GRID_X*GRID_Y cells
//  clear: one ram address zeroed per cycle across all GRID_X*GRID_Y cells
//  after reset the rams are swept to zero with in_stall high
//  one item at a time; the next beat is taken while a result waits in the
//    output register
// ---------------------------------------------------------------------------
`include "routing_congestion_accumulator_defines.svh"

module routing_congestion_accumulator import rcacc_pkg::*; #(
	parameter int GRID_X = 256,
	parameter int GRID_Y = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	// command channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           command,
	input  logic [COORD_W-1:0]   x_start,
	input  logic [COORD_W-1:0]   y_start,
	input  logic [COORD_W-1:0]   x_end,
	input  logic [COORD_W-1:0]   y_end,
	// result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           status,
	output logic [7:0]           segment_length,
	output logic [TOT_W-1:0]     total_length,
	output logic [31:0]          h_overflow,
	output logic [31:0]          v_overflow,
	output logic [32:0]          overflow_sum
);

	localparam int CELLS = GRID_X * GRID_Y;
	localparam int AW    = $clog2(CELLS);
	localparam int XW    = $clog2(GRID_X);
	localparam int YW    = $clog2(GRID_Y);
	localparam int LW    = (XW > YW) ? XW : YW;
	localparam int ACC_W = CNT_W + AW;
	localparam logic [AW-1:0] A_LAST = AW'(CELLS - 1);

	// configuration registers
	logic [CNT_W-1:0]   h_cap_q;
	logic [CNT_W-1:0]   v_cap_q;
	logic               raw_q;
	logic [COORD_W-1:0] org_l_q;
	logic [COORD_W-1:0] org_b_q;
	logic [STEP_W-1:0]  x_step_q;
	logic [STEP_W-1:0]  y_step_q;

	// control and work registers
	fsm_t               state_q, state_d;
	logic [AW-1:0]      a_q;
	logic [1:0]         c_q;
	logic [COORD_W-1:0] crd_q [4];
	bin_t               bin_q [4];
	logic [XW-1:0]      xs_q;
	logic [YW-1:0]      ys_q;
	logic [LW-1:0]      len_q;
	logic               vert_q;
	logic [TOT_W-1:0]   total_q;
	logic               rv_s1;
	logic [ACC_W-1:0]   hacc_q;
	logic [ACC_W-1:0]   vacc_q;
	status_t            sts_q;
	logic [7:0]         seg_q;

	// output register
	logic               out_valid_q;
	logic [1:0]         status_q;
	logic [7:0]         seglen_q;
	logic [TOT_W-1:0]   tot_out_q;
	logic [31:0]        hov_q;
	logic [31:0]        vov_q;

	// handshake and datapath nets
	logic               in_acc;
	logic               out_free;
	logic               div_start;
	logic               div_done;
	bin_t               div_res;
	logic [COORD_W-1:0] div_origin;
	logic [STEP_W-1:0]  div_step;
	logic               h_we;
	logic               v_we;
	logic [CNT_W-1:0]   wdata;
	logic [CNT_W-1:0]   h_rdata;
	logic [CNT_W-1:0]   v_rdata;
	logic [CNT_W-1:0]   cut_rdata;
	logic               xeq;
	logic               yeq;
	logic               diag;
	logic               outside;
	logic [TOT_W:0]     tot_sum;
	logic [31:0]        hov_sat;
	logic [31:0]        vov_sat;

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_cap_q  <= '0;
			v_cap_q  <= '0;
			raw_q    <= 1'b0;
			org_l_q  <= '0;
			org_b_q  <= '0;
			x_step_q <= STEP_W'(1);
			y_step_q <= STEP_W'(1);
		end else if (cfg_write) begin
			unique case (reg_idx_t'(cfg_index))
				REG_H_CAP:    h_cap_q  <= cfg_data[CNT_W-1:0];
				REG_V_CAP:    v_cap_q  <= cfg_data[CNT_W-1:0];
				REG_RAW:      raw_q    <= cfg_data[0];
				REG_ORIGIN_L: org_l_q  <= cfg_data;
				REG_ORIGIN_B: org_b_q  <= cfg_data;
				REG_X_STEP:   x_step_q <= cfg_data[STEP_W-1:0];
				REG_Y_STEP:   y_step_q <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- bin mapping unit ----------------
	// even coordinate slots are x, odd are y
	assign div_origin = c_q[0] ? org_b_q : org_l_q;
	assign div_step   = c_q[0] ? y_step_q : x_step_q;

	rcacc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.coord  (crd_q[c_q]),
		.origin (div_origin),
		.step   (div_step),
		.done   (div_done),
		.res    (div_res)
	);

	// ---------------- cut usage rams ----------------
	rcacc_mem #(.DEPTH(CELLS), .AW(AW)) u_hmem (
		.clk   (clk),
		.we    (h_we),
		.addr  (a_q),
		.wdata (wdata),
		.rdata (h_rdata)
	);

	rcacc_mem #(.DEPTH(CELLS), .AW(AW)) u_vmem (
		.clk   (clk),
		.we    (v_we),
		.addr  (a_q),
		.wdata (wdata),
		.rdata (v_rdata)
	);

	// vertical segments load horizontal cuts
	assign cut_rdata = vert_q ? h_rdata : v_rdata;

	// ---------------- segment checks ----------------
	assign xeq  = bin_q[0] == bin_q[2];
	assign yeq  = bin_q[1] == bin_q[3];
	assign diag = !xeq && !yeq;
	assign outside = bin_q[0].neg || bin_q[1].neg || bin_q[2].neg || bin_q[3].neg ||
		(bin_q[0].mag >= COORD_W'(GRID_X)) || (bin_q[2].mag >= COORD_W'(GRID_X)) ||
		(bin_q[1].mag >= COORD_W'(GRID_Y)) || (bin_q[3].mag >= COORD_W'(GRID_Y));

	assign tot_sum = {1'b0, total_q} + (TOT_W + 1)'(len_q);

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT: begin
				if (a_q == A_LAST) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_acc) begin
					case (cmd_t'(command))
						CMD_ADD:    state_d = raw_q ? S_MAP : S_CHECK;
						CMD_REPORT: state_d = S_RPT;
						CMD_CLEAR:  state_d = S_CLR;
						default:    state_d = S_DONE;
					endcase
				end
			end
			S_MAP:      state_d = S_MAP_WAIT;
			S_MAP_WAIT: begin
				if (div_done) state_d = (c_q == 2'd3) ? S_CHECK : S_MAP;
			end
			S_CHECK:    state_d = (diag || outside) ? S_DONE : S_ADDR;
			S_ADDR:     state_d = (len_q == '0) ? S_DONE : S_RD;
			S_RD:       state_d = S_WR;
			S_WR:       state_d = (len_q == LW'(1)) ? S_DONE : S_RD;
			S_RPT: begin
				if (a_q == A_LAST) state_d = S_RPT_END;
			end
			S_RPT_END:  state_d = S_DONE;
			S_CLR: begin
				if (a_q == A_LAST) state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default:    state_d = S_IDLE;
		endcase
	end

	// ---------------- state outputs ----------------
	always_comb begin
		in_stall  = 1'b1;
		div_start = 1'b0;
		h_we      = 1'b0;
		v_we      = 1'b0;
		wdata     = '0;
		unique case (state_q)
			S_INIT, S_CLR: begin
				h_we = 1'b1;
				v_we = 1'b1;
			end
			S_IDLE: in_stall  = 1'b0;
			S_MAP:  div_start = 1'b1;
			S_WR: begin
				// saturating bump of one cut
				h_we  = vert_q;
				v_we  = !vert_q;
				wdata = (cut_rdata == '1) ? cut_rdata : cut_rdata + 1'b1;
			end
			default: ;
		endcase
	end

	// ---------------- work registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			a_q     <= '0;
			c_q     <= '0;
			for (int i = 0; i < 4; i++) begin
				crd_q[i] <= '0;
				bin_q[i] <= '0;
			end
			xs_q    <= '0;
			ys_q    <= '0;
			len_q   <= '0;
			vert_q  <= 1'b0;
			total_q <= '0;
			rv_s1   <= 1'b0;
			hacc_q  <= '0;
			vacc_q  <= '0;
			sts_q   <= STS_OK;
			seg_q   <= '0;
		end else begin
			state_q <= state_d;
			rv_s1   <= state_q == S_RPT;

			// report accumulation, fed by the registered ram read data
			if (rv_s1) begin
				if (h_rdata > h_cap_q) hacc_q <= hacc_q + ACC_W'(h_rdata - h_cap_q);
				if (v_rdata > v_cap_q) vacc_q <= vacc_q + ACC_W'(v_rdata - v_cap_q);
			end

			case (state_q)
				S_INIT: a_q <= a_q + 1'b1;
				S_IDLE: begin
					if (in_acc) begin
						a_q    <= '0;
						c_q    <= '0;
						sts_q  <= STS_OK;
						seg_q  <= '0;
						hacc_q <= '0;
						vacc_q <= '0;
						crd_q[0] <= x_start;
						crd_q[1] <= y_start;
						crd_q[2] <= x_end;
						crd_q[3] <= y_end;
						bin_q[0] <= '{neg: 1'b0, mag: x_start};
						bin_q[1] <= '{neg: 1'b0, mag: y_start};
						bin_q[2] <= '{neg: 1'b0, mag: x_end};
						bin_q[3] <= '{neg: 1'b0, mag: y_end};
						if (cmd_t'(command) == CMD_CLEAR) total_q <= '0;
					end
				end
				S_MAP_WAIT: begin
					if (div_done) begin
						bin_q[c_q] <= div_res;
						c_q        <= c_q + 1'b1;
					end
				end
				S_CHECK: begin
					if (diag) begin
						sts_q <= STS_DIAG;
					end else if (outside) begin
						sts_q <= STS_OUTSIDE;
					end else if (xeq) begin
						// vertical run: walk y at fixed x
						vert_q <= 1'b1;
						xs_q   <= bin_q[0].mag[XW-1:0];
						if (bin_q[1].mag < bin_q[3].mag) begin
							ys_q  <= bin_q[1].mag[YW-1:0];
							len_q <= LW'(bin_q[3].mag - bin_q[1].mag);
						end else begin
							ys_q  <= bin_q[3].mag[YW-1:0];
							len_q <= LW'(bin_q[1].mag - bin_q[3].mag);
						end
					end else begin
						// horizontal run: walk x at fixed y
						vert_q <= 1'b0;
						ys_q   <= bin_q[1].mag[YW-1:0];
						if (bin_q[0].mag < bin_q[2].mag) begin
							xs_q  <= bin_q[0].mag[XW-1:0];
							len_q <= LW'(bin_q[2].mag - bin_q[0].mag);
						end else begin
							xs_q  <= bin_q[2].mag[XW-1:0];
							len_q <= LW'(bin_q[0].mag - bin_q[2].mag);
						end
					end
				end
				S_ADDR: begin
					a_q     <= AW'(xs_q) * AW'(GRID_Y) + AW'(ys_q);
					total_q <= tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];
					seg_q   <= (32'(len_q) > 32'd255) ? 8'hFF : 8'(len_q);
				end
				S_WR: begin
					len_q <= len_q - 1'b1;
					a_q   <= a_q + (vert_q ? AW'(1) : AW'(GRID_Y));
				end
				S_RPT, S_CLR: a_q <= a_q + 1'b1;
				default: ;
			endcase
		end
	end

	// ---------------- result register ----------------
	assign hov_sat = (64'(hacc_q) > 64'hFFFF_FFFF) ? '1 : 32'(hacc_q);
	assign vov_sat = (64'(vacc_q) > 64'hFFFF_FFFF) ? '1 : 32'(vacc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			status_q    <= '0;
			seglen_q    <= '0;
			tot_out_q   <= '0;
			hov_q       <= '0;
			vov_q       <= '0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
				status_q    <= sts_q;
				seglen_q    <= seg_q;
				tot_out_q   <= total_q;
				hov_q       <= hov_sat;
				vov_q       <= vov_sat;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign segment_length = seglen_q;
	assign total_length   = tot_out_q;
	assign h_overflow     = hov_q;
	assign v_overflow     = vov_q;
	assign overflow_sum   = {1'b0, hov_q} + {1'b0, vov_q};

	// ---------------- checks ----------------
	`RCACC_ASSERT_IMP(a_wr_has_cut, state_q == S_WR, len_q != '0)
	`RCACC_ASSERT_NXT(a_bin_add_direct, in_acc && cmd_t'(command) == CMD_ADD && !raw_q, state_q == S_CHECK)
	`RCACC_ASSERT_IMP(a_rpt_drained, state_q == S_DONE, !rv_s1)

endmodule

// ===== verif/rcacc_scoreboard.sv =====
// ---------------------------------------------------------------------------
// rcacc_scoreboard
// watches the cfg, command and result channels of the congestion
// accumulator, keeps its own copy of both cut grids and the wire total,
// predicts every result beat and compares it field by field
// ---------------------------------------------------------------------------
module rcacc_scoreboard import rcacc_pkg::*; #(
	parameter int GRID_X = 256,
	parameter int GRID_Y = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [1:0]           command,
	input  logic [COORD_W-1:0]   x_start,
	input  logic [COORD_W-1:0]   y_start,
	input  logic [COORD_W-1:0]   x_end,
	input  logic [COORD_W-1:0]   y_end,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [1:0]           status,
	input  logic [7:0]           segment_length,
	input  logic [TOT_W-1:0]     total_length,
	input  logic [31:0]          h_overflow,
	input  logic [31:0]          v_overflow,
	input  logic [32:0]          overflow_sum,
	output int                   pending,
	output int                   fail_count
);

	localparam int CELLS = GRID_X * GRID_Y;

	typedef struct {
		logic [1:0]       status;
		logic [7:0]       seg;
		logic [TOT_W-1:0] total;
		logic [31:0]      ho;
		logic [31:0]      vo;
		logic [32:0]      sum;
	} congestion_result_t;

	bit [CNT_W-1:0]     h_use [CELLS];
	bit [CNT_W-1:0]     v_use [CELLS];
	logic [TOT_W-1:0]   wire_total;
	congestion_result_t expected_q [$];

	logic [15:0]        h_cap, v_cap, x_stp, y_stp;
	logic               raw_mode;
	logic [23:0]        org_l, org_b;

	// floor mapping of a raw coordinate onto a bin, signed
	function automatic longint coord_bin(logic [23:0] c, logic [23:0] org, logic [15:0] stp);
		longint s, d;
		if (!raw_mode)
			return longint'(c);
		s = (stp == 0) ? 1 : longint'(stp);
		d = longint'(c) - longint'(org);
		if (d >= 0)
			return d / s;
		return -(((-d) + s - 1) / s);
	endfunction

	task automatic predict_beat(input logic [1:0] cmd, input logic [23:0] xs, ys, xe, ye,
			output congestion_result_t r);
		longint x1, y1, x2, y2, lo, hi;
		longint unsigned hs, vs;
		logic [32:0] t;
		r = '{default: '0};
		case (cmd)
			CMD_ADD: begin
				x1 = coord_bin(xs, org_l, x_stp);
				y1 = coord_bin(ys, org_b, y_stp);
				x2 = coord_bin(xe, org_l, x_stp);
				y2 = coord_bin(ye, org_b, y_stp);
				if (x1 != x2 && y1 != y2) begin
					r.status = STS_DIAG;
				end else if (x1 < 0 || x2 < 0 || y1 < 0 || y2 < 0 || x1 >= GRID_X ||
						x2 >= GRID_X || y1 >= GRID_Y || y2 >= GRID_Y) begin
					r.status = STS_OUTSIDE;
				end else begin
					if (x1 == x2) begin
						lo = (y1 < y2) ? y1 : y2;
						hi = (y1 < y2) ? y2 : y1;
						for (longint k = lo; k < hi; k++)
							if (h_use[x1*GRID_Y+k] != 16'hFFFF)
								h_use[x1*GRID_Y+k]++;
					end else begin
						lo = (x1 < x2) ? x1 : x2;
						hi = (x1 < x2) ? x2 : x1;
						for (longint k = lo; k < hi; k++)
							if (v_use[k*GRID_Y+y1] != 16'hFFFF)
								v_use[k*GRID_Y+y1]++;
					end
					t = {1'b0, wire_total} + 33'(hi - lo);
					wire_total = t[32] ? '1 : t[31:0];
					r.seg = (hi - lo > 255) ? 8'd255 : 8'(hi - lo);
				end
			end
			CMD_REPORT: begin
				hs = 0;
				vs = 0;
				for (int i = 0; i < CELLS; i++) begin
					if (h_use[i] > h_cap) hs += h_use[i] - h_cap;
					if (v_use[i] > v_cap) vs += v_use[i] - v_cap;
				end
				r.ho  = (hs > 64'hFFFF_FFFF) ? '1 : hs[31:0];
				r.vo  = (vs > 64'hFFFF_FFFF) ? '1 : vs[31:0];
				r.sum = {1'b0, r.ho} + {1'b0, r.vo};
			end
			CMD_CLEAR: begin
				foreach (h_use[i]) h_use[i] = '0;
				foreach (v_use[i]) v_use[i] = '0;
				wire_total = '0;
			end
			default: ;
		endcase
		r.total = wire_total;
	endtask

	always @(posedge clk or negedge arst_n) begin
		congestion_result_t r, e;
		if (!arst_n) begin
			foreach (h_use[i]) h_use[i] = '0;
			foreach (v_use[i]) v_use[i] = '0;
			wire_total = '0;
			h_cap = 0; v_cap = 0; raw_mode = 0; org_l = 0; org_b = 0;
			x_stp = 1; y_stp = 1;
			expected_q.delete();
			fail_count = 0;
		end else begin
			// result beat against the oldest expectation
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result beat: status %0d total %0d",
							status, total_length);
					fail_count++;
				end else begin
					e = expected_q.pop_front();
					if (status !== e.status || segment_length !== e.seg ||
							total_length !== e.total || h_overflow !== e.ho ||
							v_overflow !== e.vo || overflow_sum !== e.sum) begin
						if (fail_count < 10)
							$display({"mismatch: exp sts %0d seg %0d tot %0d ho %0d vo %0d ",
								"sum %0d, got sts %0d seg %0d tot %0d ho %0d vo %0d sum %0d"},
								e.status, e.seg, e.total, e.ho, e.vo, e.sum, status,
								segment_length, total_length, h_overflow, v_overflow,
								overflow_sum);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				predict_beat(command, x_start, y_start, x_end, y_end, r);
				expected_q.push_back(r);
			end
			if (cfg_write) begin
				case (cfg_index)
					REG_H_CAP:    h_cap    = cfg_data[15:0];
					REG_V_CAP:    v_cap    = cfg_data[15:0];
					REG_RAW:      raw_mode = cfg_data[0];
					REG_ORIGIN_L: org_l    = cfg_data[23:0];
					REG_ORIGIN_B: org_b    = cfg_data[23:0];
					REG_X_STEP:   x_stp    = cfg_data[15:0];
					REG_Y_STEP:   y_stp    = cfg_data[15:0];
					default: ;
				endcase
			end
		end
		pending = expected_q.size();
	end

endmodule

// ===== verif/tb_routing_congestion_accumulator.sv =====
// ---------------------------------------------------------------------------
// tb_routing_congestion_accumulator
// drives segment, report and clear beats through several register settings
// (bin and raw mapping, zero and max steps, capacity extremes) with random
// gaps and stalls; the scoreboard beside the block does the checking
// ---------------------------------------------------------------------------
module tb_routing_congestion_accumulator;
	import rcacc_pkg::*;

	localparam int GX = 256;
	localparam int GY = 256;
	localparam int LIMIT = 8000000;
	// command code with no action; the block still answers it with a result beat
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic                 clk, arst_n;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid, in_stall;
	logic [1:0]           command;
	logic [COORD_W-1:0]   x_start, y_start, x_end, y_end;
	logic                 out_valid, out_stall;
	logic [1:0]           status;
	logic [7:0]           segment_length;
	logic [TOT_W-1:0]     total_length;
	logic [31:0]          h_overflow, v_overflow;
	logic [32:0]          overflow_sum;
	int                   pending, fail_count;

	// shaping copies of the current setting, used only to aim coordinates
	logic                 cur_raw;
	logic [23:0]          cur_ol, cur_ob;
	logic [15:0]          cur_xs, cur_ys;
	bit                   calm;       // no gaps, no stalls
	bit                   hold_req;   // ask the receiver for a long hold-off

	routing_congestion_accumulator #(.GRID_X(GX), .GRID_Y(GY)) DUT (.*);

	rcacc_scoreboard #(.GRID_X(GX), .GRID_Y(GY)) u_scoreboard (.*);

	// clock
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("CHECKS FAILED");
		$finish;
	end

	// mostly short idles, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 88) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// result side: random stalls plus one long hold-off on request
	initial begin
		int left;
		left = 0;
		out_stall = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				left = 300;
			end
			if (left == 0 && !calm && $urandom_range(0, 3) == 0)
				left = idle_len();
			if (left > 0) begin
				out_stall <= 1;
				left--;
			end else begin
				out_stall <= 0;
			end
		end
	end

	// one command beat; valid stays high across back-to-back beats
	task automatic send_beat(input logic [1:0] cmd, input logic [23:0] xs, ys, xe, ye);
		int gap;
		gap = (calm || $urandom_range(0, 99) < 60) ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		command  <= cmd;
		x_start  <= xs;
		y_start  <= ys;
		x_end    <= xe;
		y_end    <= ye;
		do @(posedge clk); while (in_stall);
	endtask

	// drain: stop sending until every expected result has come back
	// wait on the clock first so the count includes the beat just taken
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [23:0] val);
		@(posedge clk);
		cfg_write <= 1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_write <= 0;
	endtask

	task automatic apply_setting(input logic [15:0] hcap, vcap, input logic raw,
			input logic [23:0] ol, ob, input logic [15:0] xs, ys);
		write_reg(REG_H_CAP, 24'(hcap));
		write_reg(REG_V_CAP, 24'(vcap));
		write_reg(REG_RAW, 24'(raw));
		write_reg(REG_ORIGIN_L, ol);
		write_reg(REG_ORIGIN_B, ob);
		write_reg(REG_X_STEP, 24'(xs));
		write_reg(REG_Y_STEP, 24'(ys));
		cur_raw = raw; cur_ol = ol; cur_ob = ob; cur_xs = xs; cur_ys = ys;
	endtask

	// bin index to a port coordinate under the current setting
	function automatic logic [23:0] bin_coord(longint b, logic [23:0] org, logic [15:0] stp);
		longint s, v;
		if (!cur_raw) begin
			if (b < 0) return 24'hFFFFFF - 24'($urandom_range(0, 1000));
			return b[23:0];
		end
		s = (stp == 0) ? 1 : longint'(stp);
		v = longint'(org) + b * s + longint'($urandom_range(0, s - 1));
		if (v < 0) v = 0;
		if (v > 24'hFFFFFF) v = 24'hFFFFFF;
		return v[23:0];
	endfunction

	// mostly straight in-grid segments, some diagonal, outside and noise
	task automatic random_segment();
		longint x1, y1, x2, y2, len, tmp;
		int r, p;
		r  = $urandom_range(0, 99);
		p  = $urandom_range(0, 99);
		x1 = $urandom_range(0, GX - 1);
		y1 = $urandom_range(0, GY - 1);
		len = (p < 80) ? $urandom_range(0, 6) : (p < 97) ? $urandom_range(0, 40) :
			$urandom_range(0, 255);
		x2 = x1;
		y2 = y1;
		if (r < 50) begin
			y2 = $urandom_range(0, 1) ? y1 + len : y1 - len;
			if (y2 < 0) y2 = 0;
			if (y2 > GY - 1) y2 = GY - 1;
		end else if (r < 88) begin
			x2 = $urandom_range(0, 1) ? x1 + len : x1 - len;
			if (x2 < 0) x2 = 0;
			if (x2 > GX - 1) x2 = GX - 1;
		end else if (r < 94) begin
			x2 = x1 + $urandom_range(1, 4);
			y2 = y1 - $urandom_range(1, 4);
		end else begin
			y2 = $urandom_range(0, 1) ? GY + $urandom_range(0, 3) : -1 - $urandom_range(0, 2);
		end
		if ($urandom_range(0, 1)) begin
			tmp = x1; x1 = x2; x2 = tmp;
			tmp = y1; y1 = y2; y2 = tmp;
		end
		if ($urandom_range(0, 99) < 3)
			send_beat(CMD_ADD, 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
		else
			send_beat(CMD_ADD, bin_coord(x1, cur_ol, cur_xs), bin_coord(y1, cur_ob, cur_ys),
				bin_coord(x2, cur_ol, cur_xs), bin_coord(y2, cur_ob, cur_ys));
	endtask

	// reports and clears sweep the whole grid, so they stay rare
	task automatic random_phase(input int n);
		int r;
		for (int i = 0; i < n; i++) begin
			if (i % 100 == 0)
				calm = ($urandom_range(0, 4) == 0);
			r = $urandom_range(0, 999);
			if (r < 2)
				send_beat(CMD_CLEAR, 24'($urandom), 24'($urandom), 24'($urandom),
					24'($urandom));
			else if (r < 5)
				send_beat(CMD_REPORT, 24'($urandom), 24'($urandom), 24'($urandom),
					24'($urandom));
			else if (r < 8)
				send_beat(CMD_UNUSED, 24'($urandom), 24'($urandom), 24'($urandom),
					24'($urandom));
			else
				random_segment();
		end
		calm = 0;
	endtask

	initial begin
		arst_n = 0;
		cfg_write = 0; cfg_index = '0; cfg_data = '0;
		in_valid = 0; command = '0;
		x_start = '0; y_start = '0; x_end = '0; y_end = '0;
		cur_raw = 0; cur_ol = 0; cur_ob = 0; cur_xs = 1; cur_ys = 1;
		calm = 0; hold_req = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset setting: bin indices, zero capacity
		send_beat(CMD_ADD, 5, 0, 5, 10);                // vertical wire
		send_beat(CMD_ADD, 20, 7, 3, 7);                // horizontal, reversed ends
		send_beat(CMD_ADD, 9, 9, 9, 9);                 // point segment
		send_beat(CMD_ADD, 1, 2, 3, 4);                 // diagonal
		send_beat(CMD_ADD, 300, 0, 0, 300);             // diagonal wins over outside
		send_beat(CMD_ADD, 256, 4, 256, 8);             // x just past the grid
		send_beat(CMD_ADD, 24'hFFFFFF, 0, 24'hFFFFFF, 3);
		send_beat(CMD_ADD, 0, 0, 0, 255);               // full-height wire
		send_beat(CMD_ADD, 255, 0, 0, 0);               // full-width wire
		send_beat(CMD_ADD, 255, 255, 255, 254);         // top corner
		send_beat(CMD_ADD, 5, 0, 5, 10);                // reuse of the same cuts
		send_beat(CMD_UNUSED, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		send_beat(CMD_REPORT, 0, 0, 0, 0);
		send_beat(CMD_CLEAR, 0, 0, 0, 0);
		send_beat(CMD_ADD, 7, 7, 7, 9);
		send_beat(CMD_REPORT, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		drain();

		// small capacities; result side holds off while beats keep coming
		apply_setting(16'd1, 16'd2, 1'b0, 24'd0, 24'd0, 16'd1, 16'd1);
		hold_req = 1;
		random_phase(350);
		drain();

		// raw mapping with odd steps
		apply_setting(16'd0, 16'd0, 1'b1, 24'd1000, 24'd2000, 16'd7, 16'd13);
		send_beat(CMD_ADD, 999, 2000, 999, 2070);       // one below the origin
		send_beat(CMD_ADD, 1000, 2000, 1006, 2000);     // same bin, length zero
		send_beat(CMD_ADD, 1000, 2000, 1007, 2000);     // one bin
		send_beat(CMD_ADD, 1000 + 7 * 255, 2000, 1000 + 7 * 256, 2000);
		random_phase(300);
		drain();

		// origin at the top of the range, zero steps act as one
		apply_setting(16'hFFFF, 16'hFFFF, 1'b1, 24'hFFFF00, 24'hFFFF00, 16'd0, 16'd0);
		send_beat(CMD_ADD, 24'hFFFF00, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		send_beat(CMD_ADD, 24'hFFFEFF, 24'hFFFF10, 24'hFFFEFF, 24'hFFFF20);
		random_phase(300);
		drain();

		// widest steps from a zero origin
		apply_setting(16'd3, 16'd0, 1'b1, 24'd0, 24'd0, 16'hFFFF, 16'hFFFF);
		random_phase(250);
		drain();

		// back to bin indices, extreme capacities
		apply_setting(16'hFFFF, 16'd0, 1'b0, 24'd0, 24'd0, 16'd1, 16'd1);
		random_phase(300);
		send_beat(CMD_REPORT, 0, 0, 0, 0);
		drain();
		repeat (50) @(posedge clk);

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
